// ===== hdl/e3f_pkg.sv =====
package e3f_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int GAMMA_W = 18;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
	localparam int QDEPTH = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NEG = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [2:0] ROW_MASS = 3'd0;
	localparam logic [2:0] ROW_MX = 3'd1;
	localparam logic [2:0] ROW_MY = 3'd2;
	localparam logic [2:0] ROW_MZ = 3'd3;
	localparam logic [2:0] ROW_EN = 3'd4;

	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	// One classified cell as carried from the front part to the back part.
	typedef struct packed {
		logic signed [W-1:0] rho;
		logic signed [W-1:0] mx;
		logic signed [W-1:0] my;
		logic signed [W-1:0] mz;
		logic signed [W-1:0] re;
		logic [GAMMA_W-1:0] gam;
		logic [1:0] status;
	} cell_t;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
		logic signed [W-1:0] r;
		if (v > SMAX) r = SMAX[W-1:0];
		else if (v < SMIN) r = SMIN[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	// Q product: truncate toward zero, then saturate.
	function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic neg;
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic [63:0] p;
		logic [63:0] s;
		neg = a[W-1] ^ b[W-1];
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
		p = 64'(ma) * 64'(mb);
		s = p >> FRAC_BITS;
		if (s > 64'h8000_0000) s = 64'h8000_0000;
		return sat32(neg ? -$signed(s) : $signed(s));
	endfunction

endpackage

// ===== hdl/e3f_div.sv =====
// Restoring divider: one quotient bit per cycle, returns saturated Q quotient.
module e3f_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [e3f_pkg::W-1:0] num,
	input  logic signed [e3f_pkg::W-1:0] den,
	output logic busy,
	output logic done,
	output logic signed [e3f_pkg::W-1:0] quo
);
	import e3f_pkg::*;

	localparam int NW = W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [W:0] r_q;
	logic [W-1:0] d_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [W+1:0] trial;
	logic [W:0] rsh;
	logic [NW-1:0] qsat;

	assign rsh = {r_q[W-1:0], n_q[NW-1]};
	assign trial = {1'b0, rsh} - {2'b0, d_q};

	always_comb begin
		qsat = n_q;
		if (qsat > NW'(64'h8000_0000)) qsat = NW'(64'h8000_0000);
	end

	// Shift in one numerator bit a cycle, keep the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CW'(NW);
				n_q <= {(num[W-1] ? W'(-num) : W'(num)), {FRAC_BITS{1'b0}}};
				d_q <= den[W-1] ? W'(-den) : W'(den);
				neg_q <= num[W-1] ^ den[W-1];
				r_q <= '0;
			end else if (busy) begin
				if (cnt_q == '0) begin
					busy <= 1'b0;
					done <= 1'b1;
					quo <= sat32(neg_q ? -$signed(64'(qsat)) : $signed(64'(qsat)));
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (!trial[W+1]) begin
						r_q <= trial[W:0];
						n_q <= {n_q[NW-2:0], 1'b1};
					end else begin
						r_q <= rsh;
						n_q <= {n_q[NW-2:0], 1'b0};
					end
				end
			end
		end
	end
endmodule

// ===== hdl/e3f_front.sv =====
// Front part: take cells, latch gamma, classify density sign.
module e3f_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [e3f_pkg::W-1:0] density,
	input  logic signed [e3f_pkg::W-1:0] momentum_x,
	input  logic signed [e3f_pkg::W-1:0] momentum_y,
	input  logic signed [e3f_pkg::W-1:0] momentum_z,
	input  logic signed [e3f_pkg::W-1:0] total_energy,
	input  logic [e3f_pkg::GAMMA_W-1:0] gam,
	input  logic deq,
	output logic qvalid,
	output e3f_pkg::cell_t qhead
);
	import e3f_pkg::*;

	cell_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic acc;
	cell_t c;

	assign full = (cnt_q == 2'(QDEPTH));
	assign qvalid = (cnt_q != 2'd0);
	assign qhead = mem_q[rp_q];
	assign acc = push && !full;

	// Classify the cell.
	always_comb begin
		c.rho = density;
		c.mx = momentum_x;
		c.my = momentum_y;
		c.mz = momentum_z;
		c.re = total_energy;
		c.gam = gam;
		if (density == '0) c.status = ST_ZERO;
		else if (density[W-1]) c.status = ST_NEG;
		else c.status = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (acc) mem_q[wp_q] <= c;
	end

	// Advance queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(deq);
		end
	end
endmodule

// ===== hdl/e3f_back.sv =====
// Back part: sequencer that derives primitives and streams five flux rows.
module e3f_back (
	input  logic clk,
	input  logic arst_n,
	input  logic qvalid,
	input  e3f_pkg::cell_t qhead,
	output logic deq,
	output logic empty,
	input  logic pop,
	output logic [2:0] equation_row,
	output logic signed [e3f_pkg::W-1:0] flux_x,
	output logic signed [e3f_pkg::W-1:0] flux_y,
	output logic signed [e3f_pkg::W-1:0] flux_z,
	output logic signed [e3f_pkg::W-1:0] velocity_x,
	output logic signed [e3f_pkg::W-1:0] velocity_y,
	output logic signed [e3f_pkg::W-1:0] velocity_z,
	output logic signed [e3f_pkg::W-1:0] pressure,
	output logic [e3f_pkg::W-2:0] sound_speed,
	output logic [1:0] status,
	output logic last
);
	import e3f_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_DOT1, S_DOT2, S_PRS, S_GP, S_QDIV, S_SQRT, S_EMIT
	} state_t;

	state_t st_q;
	cell_t c_q;
	logic [1:0] dsel_q;
	logic signed [W-1:0] u_q, v_q, w_q, p_q, h_q, m1_q, m2_q, m3_q, dot_q;
	logic [W-2:0] a_q;
	logic [63:0] sx_q, sres_q, sbit_q;
	logic [2:0] row_q;
	logic [1:0] st_status_q;
	logic div_start, div_busy, div_done;
	logic signed [W-1:0] div_num, div_den, div_quo;
	logic signed [W-1:0] gm1;
	logic signed [W-1:0] half;
	logic signed [W-1:0] fx, fy, fz, pa, pb, pc;
	logic [63:0] sum;
	logic out_free;

	e3f_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	assign gm1 = sat32(64'(c_q.gam) - (64'sd1 <<< FRAC_BITS));
	assign half = dot_q[W-1] ? -W'(W'(-dot_q) >> 1) : W'(dot_q >>> 1);
	assign sum = sres_q + sbit_q;
	assign out_free = empty || pop;
	assign deq = (st_q == S_IDLE) && qvalid;

	// Pick divider operands.
	always_comb begin
		div_start = 1'b0;
		div_num = c_q.mx;
		div_den = c_q.rho;
		case (st_q)
			S_DIV: begin
				div_start = !div_busy && !div_done && dsel_q != 2'd3;
				case (dsel_q)
					2'd0: div_num = c_q.mx;
					2'd1: div_num = c_q.my;
					default: div_num = c_q.mz;
				endcase
			end
			S_GP: begin
				// start gamma*p/rho once pressure is known and not negative
				div_start = dot_q[0] && !p_q[W-1];
				div_num = qmul($signed({14'b0, c_q.gam}), p_q);
			end
			default: ;
		endcase
	end

	// Select the flux row; at most one product per lane.
	always_comb begin
		pa = '0; pb = '0; pc = '0;
		case (row_q)
			ROW_MASS: begin pa = c_q.mx; pb = c_q.my; pc = c_q.mz; end
			ROW_MX: begin pa = qmul(c_q.mx, u_q); pb = qmul(c_q.mx, v_q);
				pc = qmul(c_q.mx, w_q); end
			ROW_MY: begin pa = qmul(c_q.mx, v_q); pb = qmul(c_q.my, v_q);
				pc = qmul(c_q.my, w_q); end
			ROW_MZ: begin pa = qmul(c_q.mx, w_q); pb = qmul(c_q.my, w_q);
				pc = qmul(c_q.mz, w_q); end
			default: begin pa = qmul(h_q, u_q); pb = qmul(h_q, v_q);
				pc = qmul(h_q, w_q); end
		endcase
		fx = (row_q == ROW_MX) ? sat32(64'(pa) + 64'(p_q)) : pa;
		fy = (row_q == ROW_MY) ? sat32(64'(pb) + 64'(p_q)) : pb;
		fz = (row_q == ROW_MZ) ? sat32(64'(pc) + 64'(p_q)) : pc;
		if (st_status_q != ST_OK) begin
			fx = '0; fy = '0; fz = '0;
		end
	end

	// Hold state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			empty <= 1'b1;
			dsel_q <= '0;
			row_q <= '0;
		end else begin
			// a row emitted in this cycle refills the register
			if (pop && !empty && st_q != S_EMIT) empty <= 1'b1;
			case (st_q)
				S_IDLE: if (qvalid) begin
					c_q <= qhead;
					st_status_q <= qhead.status;
					dsel_q <= '0;
					row_q <= ROW_MASS;
					st_q <= (qhead.status == ST_OK) ? S_DIV : S_EMIT;
				end
				S_DIV: if (div_done) begin
					case (dsel_q)
						2'd0: u_q <= div_quo;
						2'd1: v_q <= div_quo;
						default: w_q <= div_quo;
					endcase
					if (dsel_q == 2'd2) st_q <= S_DOT1;
					dsel_q <= dsel_q + 2'd1;
				end
				S_DOT1: begin
					m1_q <= qmul(c_q.mx, u_q);
					m2_q <= qmul(c_q.my, v_q);
					m3_q <= qmul(c_q.mz, w_q);
					st_q <= S_DOT2;
				end
				S_DOT2: begin
					dot_q <= sat32(64'(m1_q) + 64'(m2_q) + 64'(m3_q));
					st_q <= S_PRS;
				end
				S_PRS: begin
					m1_q <= sat32(64'(c_q.re) - 64'(half));
					st_q <= S_GP;
					dot_q <= '0;
				end
				default: ;
			endcase
			case (st_q)
				S_GP: begin
					if (!dot_q[0]) begin
						p_q <= qmul(m1_q, gm1);
						dot_q <= 32'sd1;
					end else if (p_q[W-1]) begin
						st_status_q <= ST_NEG;
						st_q <= S_EMIT;
					end else begin
						h_q <= sat32(64'(c_q.re) + 64'(p_q));
						st_q <= S_QDIV;
					end
				end
				S_QDIV: if (div_done) begin
					sx_q <= {div_quo, {FRAC_BITS{1'b0}}};
					sres_q <= '0;
					sbit_q <= 64'd1 << 62;
					st_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sbit_q == '0) begin
						a_q <= sres_q[W-2:0];
						st_q <= S_EMIT;
					end else begin
						if (sx_q >= sum) begin
							sx_q <= sx_q - sum;
							sres_q <= (sres_q >> 1) + sbit_q;
						end else sres_q <= sres_q >> 1;
						sbit_q <= sbit_q >> 2;
					end
				end
				S_EMIT: if (out_free) begin
					empty <= 1'b0;
					equation_row <= row_q;
					flux_x <= fx;
					flux_y <= fy;
					flux_z <= fz;
					status <= st_status_q;
					last <= (row_q == ROW_EN);
					if (st_status_q == ST_OK) begin
						velocity_x <= u_q; velocity_y <= v_q; velocity_z <= w_q;
						pressure <= p_q; sound_speed <= a_q;
					end else begin
						velocity_x <= '0; velocity_y <= '0; velocity_z <= '0;
						pressure <= '0; sound_speed <= '0;
					end
					row_q <= row_q + 3'd1;
					if (row_q == ROW_EN) st_q <= S_IDLE;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hdl/euler_3d_primitive_and_flux_core.sv =====
// Primitive recovery and inviscid 3D Euler flux in signed Q16.16. Each cell
// pushed in yields five result rows (mass, x/y/z momentum, energy) popped from
// the result register, each carrying its row's fluxes and the cell's velocity,
// pressure, sound speed and status. A two-entry queue decouples intake from
// the sequencer. A valid cell passes intake, three divisions in the shared
// restoring divider for the velocities, the dot product and pressure, one more
// division for gamma*p/rho and the bit-pair square root before its rows are
// emitted; a cell whose pressure turns out negative skips the last division
// and the root, and a cell with zero or negative density goes straight to
// emitting its rows. Holding pop low while a row waits stalls the sequencer.
// gamma is written at byte address 0 through the APB port and is captured per
// cell at intake.
module euler_3d_primitive_and_flux_core (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic push,
	output logic full,
	input  logic signed [31:0] density,
	input  logic signed [31:0] momentum_x,
	input  logic signed [31:0] momentum_y,
	input  logic signed [31:0] momentum_z,
	input  logic signed [31:0] total_energy,
	output logic empty,
	input  logic pop,
	output logic [2:0] equation_row,
	output logic signed [31:0] flux_x,
	output logic signed [31:0] flux_y,
	output logic signed [31:0] flux_z,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic signed [31:0] velocity_z,
	output logic signed [31:0] pressure,
	output logic [30:0] sound_speed,
	output logic [1:0] status,
	output logic last
);
	import e3f_pkg::*;

	logic [GAMMA_W-1:0] gamma_q;
	logic deq, qvalid;
	cell_t qhead;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(gamma_q) : 32'd0;

	// Write gamma register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gamma_q <= GAMMA_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) gamma_q <= pwdata[GAMMA_W-1:0];
	end

	e3f_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .density(density),
		.momentum_x(momentum_x), .momentum_y(momentum_y), .momentum_z(momentum_z),
		.total_energy(total_energy), .gam(gamma_q), .deq(deq), .qvalid(qvalid),
		.qhead(qhead)
	);

	e3f_back u_back (
		.clk(clk), .arst_n(arst_n), .qvalid(qvalid), .qhead(qhead), .deq(deq),
		.empty(empty), .pop(pop), .equation_row(equation_row), .flux_x(flux_x),
		.flux_y(flux_y), .flux_z(flux_z), .velocity_x(velocity_x),
		.velocity_y(velocity_y), .velocity_z(velocity_z), .pressure(pressure),
		.sound_speed(sound_speed), .status(status), .last(last)
	);
endmodule

// ===== hdl/e3f_checker.sv =====
// Port-level checks on the result stream.
module e3f_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [2:0] equation_row,
	input logic [1:0] status,
	input logic last,
	input logic [31:0] flux_x,
	input logic [31:0] pressure
);
	import e3f_pkg::*;

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (equation_row == ROW_EN))) else $error("last mismatch");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> equation_row <= ROW_EN) else $error("row range");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (flux_x == 32'd0 && pressure == 32'd0))
		else $error("bad cell not zeroed");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(equation_row))) else $error("item lost");
endmodule

bind euler_3d_primitive_and_flux_core e3f_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .equation_row(equation_row),
	.status(status), .last(last), .flux_x(flux_x), .pressure(pressure)
);
